// File: design/integer_to_radix_text_macros.svh
// assertion macros shared by the integer-to-text modules
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ITRT_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ITRT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition holds at every edge out of reset
`define ITRT_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// File: design/itrt_pkg.sv
// shared constants, radix codes and character helpers for integer-to-text conversion
package itrt_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h41;

  // decimal digits needed for a magnitude up to 2^(vb-1)
  function automatic int dec_digits(int vb);
    return ((vb - 1) * 30103) / 100000 + 1;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + 8'(d);
    end else begin
      ch = CH_ALPHA + 8'(d) - 8'd10;
    end
    return ch;
  endfunction

endpackage

// File: design/itrt_front.sv
// front end: takes a value, forms its magnitude, bit length and bcd digits serially
`include "integer_to_radix_text_macros.svh"

module itrt_front #(
  parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic [VALUE_BITS-1:0]                          value_i,
  input  itrt_pkg::radix_e                               radix_i,
  output logic                                           ent_valid_o,
  input  logic                                           ent_ready_i,
  output itrt_pkg::radix_e                               ent_radix_o,
  output logic                                           ent_neg_o,
  output logic [$clog2(VALUE_BITS+1)-1:0]                ent_len_o,
  output logic [VALUE_BITS-1:0]                          ent_twos_o,
  output logic [4*itrt_pkg::dec_digits(VALUE_BITS)-1:0]  ent_bcd_o
);

  localparam int ND = itrt_pkg::dec_digits(VALUE_BITS);
  localparam int IW = $clog2(VALUE_BITS + 1);
  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_BITS - 1);

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} state_e;

  state_e                state_q;
  logic [CW-1:0]         step_q;
  logic                  found_q;
  logic [IW-1:0]         n_q;
  logic [VALUE_BITS-1:0] sh_q;
  logic [4*ND-1:0]       bcd_q;
  logic [4*ND-1:0]       bcd_adj;
  logic [VALUE_BITS-1:0] twos_q;
  logic                  neg_q;
  itrt_pkg::radix_e      radix_q;
  logic [VALUE_BITS-1:0] mag;

  assign mag = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      if (bcd_q[4*j +: 4] >= 4'd5) begin
        bcd_adj[4*j +: 4] = bcd_q[4*j +: 4] + 4'd3;
      end else begin
        bcd_adj[4*j +: 4] = bcd_q[4*j +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            state_q <= F_RUN;
            step_q  <= '0;
          end
        end
        F_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (ent_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      neg_q   <= value_i[VALUE_BITS-1];
      twos_q  <= value_i;
      radix_q <= radix_i;
      sh_q    <= mag;
      bcd_q   <= '0;
      n_q     <= IW'(1);
      found_q <= 1'b0;
    end else if (state_q == F_RUN) begin
      {bcd_q, sh_q} <= {bcd_adj[4*ND-2:0], sh_q, 1'b0};
      // first one out of the top gives the bit length
      if (!found_q && sh_q[VALUE_BITS-1]) begin
        found_q <= 1'b1;
        n_q     <= IW'(VALUE_BITS) - IW'(step_q);
      end
    end
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign ent_valid_o = (state_q == F_PUSH);
  assign ent_radix_o = radix_q;
  assign ent_neg_o   = neg_q;
  assign ent_len_o   = n_q;
  assign ent_twos_o  = twos_q;
  assign ent_bcd_o   = bcd_q;

  `ITRT_ASSERT_NEXT(a_accept_starts_scan, in_valid_i && in_ready_o, state_q == F_RUN && step_q == '0, "scan did not start")
  `ITRT_ASSERT_ALWAYS(a_len_nonzero, state_q != F_PUSH || n_q != '0, "bit length of zero")
  `ITRT_ASSERT_IMPLY(a_push_after_full_scan, $rose(ent_valid_o), $past(state_q) == F_RUN && $past(step_q) == LAST_STEP, "entry offered early")

endmodule

// File: design/itrt_queue.sv
// two-entry queue between the front end and the character emitter
module itrt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (itrt_pkg::QUEUE_DEPTH > 1) ? $clog2(itrt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(itrt_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [itrt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CNTW-1:0]  count_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNTW'(itrt_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/itrt_back.sv
// back end: walks the digits of one entry and emits one character per cycle while the receiver is ready
`include "integer_to_radix_text_macros.svh"

module itrt_back #(
  parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           ent_valid_i,
  output logic                                           ent_ready_o,
  input  itrt_pkg::radix_e                               ent_radix_i,
  input  logic                                           ent_neg_i,
  input  logic [$clog2(VALUE_BITS+1)-1:0]                ent_len_i,
  input  logic [VALUE_BITS-1:0]                          ent_twos_i,
  input  logic [4*itrt_pkg::dec_digits(VALUE_BITS)-1:0]  ent_bcd_i,
  output logic                                           char_valid_o,
  input  logic                                           char_ready_i,
  output logic [7:0]                                     char_code_o,
  output logic                                           char_last_o
);

  localparam int ND = itrt_pkg::dec_digits(VALUE_BITS);
  localparam int IW = $clog2(VALUE_BITS + 1);
  localparam int PW = $clog2(VALUE_BITS + 4);
  localparam int BW = $clog2(VALUE_BITS);
  localparam int DW = $clog2(ND);

  logic                  busy_q;
  itrt_pkg::radix_e      rad_q;
  logic                  sign_q;
  logic                  lead_q;
  logic [IW-1:0]         idx_q;
  logic [VALUE_BITS-1:0] twos_q;
  logic                  neg_q;
  logic [4*ND-1:0]       bcd_q;
  logic                  valid_q;
  logic [7:0]            char_q;
  logic                  last_q;

  logic                  load;
  logic                  can_load;
  logic                  step;
  logic                  skip;
  logic                  emit;
  logic                  emit_last;
  logic [7:0]            emit_char;
  logic [IW-1:0]         start_idx;
  logic [15:0]           oct_prod;
  logic [PW-1:0]         idx_w;
  logic [PW-1:0]         base;
  logic [3:0]            grp_digit;
  logic [3:0]            dec_digit;
  logic [3:0]            cur_digit;
  logic                  bin_bit;

  // bit k of the value sign-extended without bound
  function automatic logic bit_at(logic [VALUE_BITS-1:0] tw, logic ng, logic [PW-1:0] k);
    logic b;
    if (k < PW'(VALUE_BITS)) begin
      b = tw[k[BW-1:0]];
    end else begin
      b = ng;
    end
    return b;
  endfunction

  assign ent_ready_o = !busy_q;
  assign load        = ent_valid_i && !busy_q;
  assign can_load    = !valid_q || char_ready_i;
  assign step        = busy_q && can_load;

  // top digit index: n for binary, floor(n/3) for octal, floor(n/4) for hex, ND-1 for decimal
  assign oct_prod = 16'(ent_len_i) * 16'd171;

  always_comb begin
    case (ent_radix_i)
      itrt_pkg::RADIX_BIN: start_idx = ent_len_i;
      itrt_pkg::RADIX_OCT: start_idx = IW'(oct_prod >> 9);
      itrt_pkg::RADIX_HEX: start_idx = ent_len_i >> 2;
      itrt_pkg::RADIX_DEC: start_idx = IW'(ND - 1);
      default:             start_idx = ent_len_i;
    endcase
  end

  assign idx_w = PW'(idx_q);
  assign base  = (rad_q == itrt_pkg::RADIX_HEX) ? (idx_w << 2) : ((idx_w << 1) + idx_w);

  always_comb begin
    grp_digit[0] = bit_at(twos_q, neg_q, base);
    grp_digit[1] = bit_at(twos_q, neg_q, base + PW'(1));
    grp_digit[2] = bit_at(twos_q, neg_q, base + PW'(2));
    grp_digit[3] = (rad_q == itrt_pkg::RADIX_HEX) ? bit_at(twos_q, neg_q, base + PW'(3)) : 1'b0;
  end

  assign dec_digit = bcd_q[{idx_q[DW-1:0], 2'b00} +: 4];
  assign cur_digit = (rad_q == itrt_pkg::RADIX_DEC) ? dec_digit : grp_digit;
  assign bin_bit   = bit_at(twos_q, neg_q, idx_w);

  // leading zero digit: octal and hex drop one, decimal drops all but the last
  assign skip = lead_q && !sign_q && (rad_q != itrt_pkg::RADIX_BIN) &&
                (cur_digit == 4'd0) && (idx_q != '0);
  assign emit      = step && !skip;
  assign emit_last = !sign_q && (idx_q == '0);

  always_comb begin
    if (sign_q) begin
      emit_char = itrt_pkg::CH_MINUS;
    end else if (rad_q == itrt_pkg::RADIX_BIN) begin
      emit_char = itrt_pkg::CH_ZERO + 8'(bin_bit);
    end else begin
      emit_char = itrt_pkg::digit_char(cur_digit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rad_q   <= itrt_pkg::RADIX_BIN;
      sign_q  <= 1'b0;
      lead_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        rad_q  <= ent_radix_i;
        sign_q <= (ent_radix_i == itrt_pkg::RADIX_DEC) && ent_neg_i;
        lead_q <= 1'b1;
        idx_q  <= start_idx;
      end else if (step) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else begin
          lead_q <= skip && (rad_q == itrt_pkg::RADIX_DEC);
          if (idx_q == '0) begin
            busy_q <= 1'b0;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
      end
      if (can_load) begin
        valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      twos_q <= ent_twos_i;
      neg_q  <= ent_neg_i;
      bcd_q  <= ent_bcd_i;
    end
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
    end
  end

  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign char_last_o  = last_q;

  `ITRT_ASSERT_IMPLY(a_sign_only_decimal, sign_q, rad_q == itrt_pkg::RADIX_DEC, "minus pending outside decimal")
  `ITRT_ASSERT_NEXT(a_last_ends_item, emit && emit_last, !busy_q, "emitter busy after last char")
  `ITRT_ASSERT_IMPLY(a_dec_idx_range, busy_q && rad_q == itrt_pkg::RADIX_DEC, idx_q < IW'(ND), "decimal digit index out of range")

endmodule

// File: design/integer_to_radix_text.sv
// top level: signed integer to ascii text in radix 2, 8, 10 or 16
//
//  channel  dir  tdata                  tuser            tlast
//  s_axis   in   value                  radix_code       -
//  m_axis   out  char_code              -                last_char
//
// front end takes one bcd shift step per magnitude bit and accepts a new value only
// after the last one has been handed on to the queue
// back end: loads an entry, then emits one character per cycle while the receiver is ready;
// every dropped leading zero digit (all of them in decimal, the single one in octal and hex)
// passes without a character; binary text is up to VALUE_BITS+1 characters
// a two-entry queue between front and back lets either side stall on its own
// reset is asynchronous, active low, and empties queue, front end and output register
module integer_to_radix_text #(
  parameter int VALUE_BITS = itrt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_axis_tdata,   // value
  input  logic [1:0]                           s_axis_tuser,   // radix_code
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // char_code
  output logic                                 m_axis_tlast    // last_char
);

  localparam int ND    = itrt_pkg::dec_digits(VALUE_BITS);
  localparam int IW    = $clog2(VALUE_BITS + 1);
  localparam int O_NEG = 2;
  localparam int O_LEN = O_NEG + 1;
  localparam int O_TW  = O_LEN + IW;
  localparam int O_BCD = O_TW + VALUE_BITS;
  localparam int ENT_W = O_BCD + 4 * ND;

  logic                  f_valid;
  logic                  f_ready;
  itrt_pkg::radix_e      f_radix;
  logic                  f_neg;
  logic [IW-1:0]         f_len;
  logic [VALUE_BITS-1:0] f_twos;
  logic [4*ND-1:0]       f_bcd;
  logic [ENT_W-1:0]      push_data;
  logic [ENT_W-1:0]      pop_data;
  logic                  q_valid;
  logic                  q_ready;

  itrt_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .value_i     (s_axis_tdata[VALUE_BITS-1:0]),
    .radix_i     (itrt_pkg::radix_e'(s_axis_tuser)),
    .ent_valid_o (f_valid),
    .ent_ready_i (f_ready),
    .ent_radix_o (f_radix),
    .ent_neg_o   (f_neg),
    .ent_len_o   (f_len),
    .ent_twos_o  (f_twos),
    .ent_bcd_o   (f_bcd)
  );

  assign push_data = {f_bcd, f_twos, f_len, f_neg, f_radix};

  itrt_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (pop_data)
  );

  itrt_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (q_valid),
    .ent_ready_o  (q_ready),
    .ent_radix_i  (itrt_pkg::radix_e'(pop_data[1:0])),
    .ent_neg_i    (pop_data[O_NEG]),
    .ent_len_i    (pop_data[O_LEN +: IW]),
    .ent_twos_i   (pop_data[O_TW +: VALUE_BITS]),
    .ent_bcd_i    (pop_data[O_BCD +: 4*ND]),
    .char_valid_o (m_axis_tvalid),
    .char_ready_i (m_axis_tready),
    .char_code_o  (m_axis_tdata),
    .char_last_o  (m_axis_tlast)
  );

endmodule

// File: verif/tb_integer_to_radix_text.sv
// testbench for integer_to_radix_text: directed table then random values, self-checking
`timescale 1ns / 1ps

module tb_integer_to_radix_text;

  localparam int N_ROWS     = 25;
  localparam int N_RANDOM   = 450;
  localparam int QUIET_FROM = 390;     // random items from here on run with no idling
  localparam int HOLD_AT    = 150;     // random item that triggers the long receiver hold
  localparam int HOLD_LEN   = 250;
  localparam int DRAIN_WAIT = 40;
  localparam int MAX_CYCLES = 500000;

  typedef logic [7:0] text_q_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  typedef struct {
    logic [31:0]       value;
    itrt_pkg::radix_e  radix;
    string             text;    // empty: predicted
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // value
  logic [1:0]  s_axis_tuser;   // radix_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // char_code
  logic        m_axis_tlast;   // last_char

  text_char_t pending_chars[$];
  int         mismatches;
  int         cycles;
  bit         idle_on;
  bit         hold_req;

  stim_row_t dir_rows [N_ROWS] = '{
    '{32'd0,          itrt_pkg::RADIX_BIN, "00"},
    '{32'd0,          itrt_pkg::RADIX_OCT, "0"},
    '{32'd0,          itrt_pkg::RADIX_DEC, "0"},
    '{32'd0,          itrt_pkg::RADIX_HEX, "0"},
    '{32'd1,          itrt_pkg::RADIX_BIN, "01"},
    '{32'hFFFF_FFFF,  itrt_pkg::RADIX_BIN, "11"},
    '{32'hFFFF_FFFF,  itrt_pkg::RADIX_OCT, "7"},
    '{32'hFFFF_FFFF,  itrt_pkg::RADIX_DEC, "-1"},
    '{32'hFFFF_FFFF,  itrt_pkg::RADIX_HEX, "F"},
    '{32'h7FFF_FFFF,  itrt_pkg::RADIX_DEC, "2147483647"},
    '{32'h7FFF_FFFF,  itrt_pkg::RADIX_HEX, "7FFFFFFF"},
    '{32'h7FFF_FFFF,  itrt_pkg::RADIX_OCT, "17777777777"},
    '{32'h7FFF_FFFF,  itrt_pkg::RADIX_BIN, ""},
    '{32'h8000_0000,  itrt_pkg::RADIX_DEC, "-2147483648"},
    '{32'h8000_0000,  itrt_pkg::RADIX_BIN, ""},
    '{32'h8000_0000,  itrt_pkg::RADIX_OCT, ""},
    '{32'h8000_0000,  itrt_pkg::RADIX_HEX, ""},
    '{32'h8000_0001,  itrt_pkg::RADIX_BIN, ""},
    '{32'd10,         itrt_pkg::RADIX_HEX, "A"},
    '{32'd255,        itrt_pkg::RADIX_HEX, "FF"},
    '{32'd8,          itrt_pkg::RADIX_OCT, "10"},
    '{32'd7,          itrt_pkg::RADIX_OCT, "7"},
    '{32'hFFFF_FFF8,  itrt_pkg::RADIX_HEX, "F8"},
    '{32'hFFFF_FF01,  itrt_pkg::RADIX_DEC, "-255"},
    '{32'd123456789,  itrt_pkg::RADIX_HEX, "75BCD15"}
  };

  integer_to_radix_text dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // text of one value, most significant character first
  function automatic text_q_t format_value(input logic [31:0] v, input itrt_pkg::radix_e r);
    text_q_t    txt;
    logic [3:0] dec_q[$];
    logic [63:0] twos;
    logic [63:0] mag;
    logic       neg;
    logic [3:0] d;
    bit         first;
    int         n, len, g, ndig, k, i, b;
    neg  = v[31];
    twos = {{32{v[31]}}, v};
    mag  = neg ? -twos : twos;
    n = 0;
    while (n < 64 && (mag >> n) != 64'd0) n++;
    if (n == 0) n = 1;
    len = n + 1;
    case (r)
      itrt_pkg::RADIX_DEC: begin
        if (neg) txt.push_back(itrt_pkg::CH_MINUS);
        do begin
          dec_q.push_front(4'(mag % 64'd10));
          mag = mag / 64'd10;
        end while (mag != 64'd0);
        foreach (dec_q[j]) txt.push_back(itrt_pkg::CH_ZERO + 8'(dec_q[j]));
      end
      itrt_pkg::RADIX_BIN: begin
        for (k = len - 1; k >= 0; k--) txt.push_back(itrt_pkg::CH_ZERO + 8'(twos[k]));
      end
      default: begin
        g     = (r == itrt_pkg::RADIX_OCT) ? 3 : 4;
        ndig  = (len + g - 1) / g;
        first = 1'b1;
        for (i = ndig - 1; i >= 0; i--) begin
          d = 4'd0;
          for (b = g - 1; b >= 0; b--) d = {d[2:0], twos[i * g + b]};
          // one leading zero digit goes away when more digits follow
          if (!(first && d == 4'd0 && ndig > 1)) begin
            txt.push_back((d < 4'd10) ? itrt_pkg::CH_ZERO + 8'(d)
                                      : itrt_pkg::CH_ALPHA + 8'(d) - 8'd10);
          end
          first = 1'b0;
        end
      end
    endcase
    return txt;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: v = $urandom;
      3, 4, 5: v = $urandom_range(0, 40);
      6, 7:    v = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
      8:       v = $urandom_range(0, 99999);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h8000_0001;
          default: v = 32'd0;
        endcase
      end
    endcase
    if (sel >= 3 && sel <= 8 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
    end
  endtask

  // offers one value and queues its text once the transaction completes
  task automatic send_value(input logic [31:0] v, input itrt_pkg::radix_e r,
                            input string typed);
    text_q_t txt;
    int      gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed.len() > 0) begin
      for (int j = 0; j < typed.len(); j++) txt.push_back(8'(typed[j]));
    end else begin
      txt = format_value(v, r);
    end
    foreach (txt[j]) pending_chars.push_back('{ch: txt[j], last: (j == txt.size() - 1)});
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("** integer_to_radix_text: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", 0, m_axis_tdata);
      end else begin
        exp_c = pending_chars.pop_front();
        if (m_axis_tdata !== exp_c.ch) report_mismatch("char_code", exp_c.ch, m_axis_tdata);
        if (m_axis_tlast !== exp_c.last) report_mismatch("last_char", exp_c.last, m_axis_tlast);
      end
    end
  end

  // receiver: short stall bursts, plus one long hold so the input side backs up
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    itrt_pkg::radix_e r;
    cycles        = 0;
    mismatches    = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_value(dir_rows[i].value, dir_rows[i].radix, dir_rows[i].text);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == QUIET_FROM) idle_on = 1'b0;
      r = itrt_pkg::radix_e'($urandom_range(0, 3));
      send_value(pick_value(), r, "");
    end
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** integer_to_radix_text: PASSED **");
    end else begin
      $display("** integer_to_radix_text: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/itrt_pkg.sv
design/itrt_front.sv
design/itrt_queue.sv
design/itrt_back.sv
design/integer_to_radix_text.sv
verif/tb_integer_to_radix_text.sv
